[rtl/frm_pkg.sv]
// shared widths and constants for the frame rate meter
package frm_pkg;

	localparam int TS_W       = 32;
	localparam int US_W       = 32;
	localparam int FRAMES_W   = 5;
	localparam int RATE_W     = 28;
	localparam int US_PER_S_W = 20;
	localparam int WINDOW_DEF = 30;

	localparam logic [US_PER_S_W-1:0] US_PER_S   = 20'd1000000;
	// 1e6 frames per second in Q20.8, also the rate shown with an empty window
	localparam logic [RATE_W-1:0]     RATE_SCALE = 28'd256000000;
	localparam logic [RATE_W-1:0]     RATE_MAX   = 28'hFFFFFFF;
	localparam logic [TS_W-1:0]       TICK_RATE_RST = 32'd1000000;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_END   = 1'b1;

endpackage

[rtl/frame_rate_meter_core.sv]
// frame rate meter: frame time capture, moving window sum and bit-serial rate division
//
// usage: one input channel (in_valid/in_stall) carries events with action and timestamp;
// action start latches the timestamp, action end measures the elapsed ticks since the
// latched start, converts them to microseconds and adds the frame to a window of WINDOW
// frame times. every event, start or end, gives one transfer on the output channel
// (out_valid/out_stall) with the newest frame time, the frame count (masked to 5 bits)
// and the average frame rate in unsigned Q20.8.
// steps: a start event passes S_IDLE and S_EMIT before its result is registered. an end
// event also passes S_MUL1, S_DIV1, S_UPD, S_MUL2, S_DIV2 and S_RATE, using one shared
// restoring divider that retires one quotient bit per cycle: first ticks*1e6/tick_rate,
// then 256e6*frames/window_sum. one event is worked on at a time; in_stall is high while
// an event is in flight.
// stalls: a finished result waits in the output register while out_stall is high; a
// new event may be taken in the meantime and waits before its own result is written.
// reset: tick_rate returns to 1000000, the window empties, the held frame time is 0 and
// the held rate 1000000.0. the user must write tick_rate through cfg_wr_en/cfg_wr_data
// only while no event is in flight; the block itself does not enforce this.
module frame_rate_meter_core #(
	parameter int WINDOW = frm_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [frm_pkg::TS_W-1:0]      cfg_wr_data,
	// event channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [frm_pkg::TS_W-1:0]      timestamp,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [frm_pkg::US_W-1:0]      last_frame_us,
	output logic [frm_pkg::FRAMES_W-1:0]  frames_in_window,
	output logic [frm_pkg::RATE_W-1:0]    frame_rate
);
	import frm_pkg::*;

	// widths that follow from the window depth
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W  = US_W + CNT_W;
	localparam int PROD_W = TS_W + US_PER_S_W;          // ticks * 1e6
	localparam int NUM_W  = RATE_W + CNT_W;             // 256e6 * frames
	localparam int DIV_NW = (PROD_W > NUM_W) ? PROD_W : NUM_W;
	localparam int ITER_W = $clog2(DIV_NW + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;
	localparam logic [2:0] S_DIV1 = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_MUL2 = 3'd4;
	localparam logic [2:0] S_DIV2 = 3'd5;
	localparam logic [2:0] S_RATE = 3'd6;
	localparam logic [2:0] S_EMIT = 3'd7;

	logic [2:0]        state_q;
	logic [TS_W-1:0]   tick_rate_q;
	logic [TS_W-1:0]   start_stamp_q;
	logic [TS_W-1:0]   ticks_q;
	logic [US_W-1:0]   ring_q [WINDOW];
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [US_W-1:0]   newest_q;
	logic [RATE_W-1:0] rate_q;

	// shared divider: quotient bits shift into the low end of num_q
	logic [DIV_NW-1:0] num_q;
	logic [SUM_W-1:0]  rem_q;
	logic [ITER_W-1:0] iter_q;

	logic              out_valid_q;
	logic [US_W-1:0]   out_us_q;
	logic [FRAMES_W-1:0] out_frames_q;
	logic [RATE_W-1:0] out_rate_q;

	logic              in_xfer;
	logic              out_xfer;
	logic              out_free;
	logic              window_full;
	logic [US_W-1:0]   old_time;
	logic [SUM_W-1:0]  den;
	logic [SUM_W:0]    rem_sh;
	logic              rem_ge;
	logic [SUM_W:0]    rem_diff;
	logic [US_W-1:0]   us_sat;
	logic [RATE_W-1:0] rate_sat;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// a slot has been written before only once the window has filled
	assign window_full = (count_q == CNT_W'(WINDOW));
	assign old_time    = window_full ? ring_q[slot_q] : '0;

	// one quotient bit per cycle
	assign den      = (state_q == S_DIV1) ? SUM_W'(tick_rate_q) : sum_q;
	assign rem_sh   = {rem_q, num_q[DIV_NW-1]};
	assign rem_ge   = (rem_sh >= {1'b0, den});
	assign rem_diff = rem_sh - {1'b0, den};

	// saturate the quotients to their fields (a zero divisor gives all ones)
	assign us_sat   = (num_q[DIV_NW-1:US_W] != '0) ? {US_W{1'b1}} : num_q[US_W-1:0];
	assign rate_sat = (num_q[NUM_W-1:RATE_W] != '0) ? RATE_MAX : num_q[RATE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= TICK_RATE_RST;
		end else if (cfg_wr_en) begin
			tick_rate_q <= cfg_wr_data;
		end
	end

	// frame time ring, no reset: entries are read only after the window has filled
	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			ring_q[slot_q] <= us_sat;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ticks_q <= timestamp - start_stamp_q;
			end
			S_MUL1: begin
				num_q  <= DIV_NW'(ticks_q) * DIV_NW'(US_PER_S);
				rem_q  <= '0;
				iter_q <= ITER_W'(DIV_NW);
			end
			S_MUL2: begin
				// left-align the numerator so NUM_W steps finish the division
				num_q  <= DIV_NW'(NUM_W'(RATE_SCALE) * NUM_W'(count_q)) << (DIV_NW - NUM_W);
				rem_q  <= '0;
				iter_q <= ITER_W'(NUM_W);
			end
			S_DIV1, S_DIV2: begin
				num_q  <= {num_q[DIV_NW-2:0], rem_ge};
				rem_q  <= rem_ge ? rem_diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
				iter_q <= iter_q - ITER_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			start_stamp_q <= '0;
			slot_q        <= '0;
			count_q       <= '0;
			sum_q         <= '0;
			newest_q      <= '0;
			rate_q        <= RATE_SCALE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (action == ACT_START) begin
							start_stamp_q <= timestamp;
							state_q       <= S_EMIT;
						end else begin
							state_q <= S_MUL1;
						end
					end
				end
				S_MUL1: begin
					// take the retiring frame out of the sum early
					sum_q   <= sum_q - SUM_W'(old_time);
					state_q <= S_DIV1;
				end
				S_DIV1: begin
					if (iter_q == ITER_W'(1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					sum_q    <= sum_q + SUM_W'(us_sat);
					newest_q <= us_sat;
					slot_q   <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
					if (!window_full) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q  <= S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (iter_q == ITER_W'(1)) begin
						state_q <= S_RATE;
					end
				end
				S_RATE: begin
					rate_q  <= rate_sat;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// hold until the output register can take the result
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_us_q     <= newest_q;
			out_frames_q <= FRAMES_W'(count_q);
			out_rate_q   <= rate_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign last_frame_us    = out_us_q;
	assign frames_in_window = out_frames_q;
	assign frame_rate       = out_rate_q;

endmodule
